// ===== rtl/core/rdsctd_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsctd_pkg
// Shared constants and types of the RDS clock-time and date decoder.
// ----------------------------------------------------------------------------
package rdsctd_pkg;

    // mjd window covered by the year table (2000-01-00 .. 2099-11-30)
    localparam int unsigned MJD_LOW    = 51543;
    localparam int unsigned MJD_HIGH   = 88037;
    localparam int unsigned YEAR_COUNT = 100;

    localparam int unsigned YEAR_W     = 7;
    localparam int unsigned DIDX_W     = 16;
    localparam int unsigned BASE_W     = 16;

    // time fields after the local offset, plus the day index for the date walk
    typedef struct packed {
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic              in_range;
        logic [DIDX_W-1:0] day_idx;
    } tadj_t;

    // held calendar date
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
    } date_t;

    // date walk status back to the control
    typedef struct packed {
        logic done;
        logic in_range;
    } dres_t;

endpackage

// ===== rtl/core/rdsctd_year_rom.sv =====
// ----------------------------------------------------------------------------
// rdsctd_year_rom
// Synchronous table of year starts, days from MJD 51543 to the day before
// January 1 of each year 2000..2099. One read port, registered data.
// ----------------------------------------------------------------------------
module rdsctd_year_rom (
    input  logic                              aclk,
    input  logic [rdsctd_pkg::YEAR_W-1:0]     rd_addr,
    output logic [rdsctd_pkg::BASE_W-1:0]     rd_data
);

    localparam logic [rdsctd_pkg::BASE_W-1:0] YEAR_BASE [0:rdsctd_pkg::YEAR_COUNT-1] = '{
        16'd0,     16'd366,   16'd731,   16'd1096,  16'd1461,
        16'd1827,  16'd2192,  16'd2557,  16'd2922,  16'd3288,
        16'd3653,  16'd4018,  16'd4383,  16'd4749,  16'd5114,
        16'd5479,  16'd5844,  16'd6210,  16'd6575,  16'd6940,
        16'd7305,  16'd7671,  16'd8036,  16'd8401,  16'd8766,
        16'd9132,  16'd9497,  16'd9862,  16'd10227, 16'd10593,
        16'd10958, 16'd11323, 16'd11688, 16'd12054, 16'd12419,
        16'd12784, 16'd13149, 16'd13515, 16'd13880, 16'd14245,
        16'd14610, 16'd14976, 16'd15341, 16'd15706, 16'd16071,
        16'd16437, 16'd16802, 16'd17167, 16'd17532, 16'd17898,
        16'd18263, 16'd18628, 16'd18993, 16'd19359, 16'd19724,
        16'd20089, 16'd20454, 16'd20820, 16'd21185, 16'd21550,
        16'd21915, 16'd22281, 16'd22646, 16'd23011, 16'd23376,
        16'd23742, 16'd24107, 16'd24472, 16'd24837, 16'd25203,
        16'd25568, 16'd25933, 16'd26298, 16'd26664, 16'd27029,
        16'd27394, 16'd27759, 16'd28125, 16'd28490, 16'd28855,
        16'd29220, 16'd29586, 16'd29951, 16'd30316, 16'd30681,
        16'd31047, 16'd31412, 16'd31777, 16'd32142, 16'd32508,
        16'd32873, 16'd33238, 16'd33603, 16'd33969, 16'd34334,
        16'd34699, 16'd35064, 16'd35430, 16'd35795, 16'd36160
    };

    logic [rdsctd_pkg::BASE_W-1:0] rd_data_reg;

    // registered read
    always_ff @(posedge aclk) begin
        rd_data_reg <= YEAR_BASE[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rdsctd_time_adj.sv =====
// ----------------------------------------------------------------------------
// rdsctd_time_adj
// Unpacks blocks B, C and D, applies the signed half-hour offset to minute
// and hour in closed form and shifts the MJD by the resulting day carry.
// ----------------------------------------------------------------------------
module rdsctd_time_adj (
    input  logic [15:0]        block_b,
    input  logic [15:0]        block_c,
    input  logic [15:0]        block_d,
    output rdsctd_pkg::tadj_t  tadj
);

    logic [4:0]  hr_in;
    logic [5:0]  mn_in;
    logic        neg;
    logic [4:0]  halves;
    logic [5:0]  mn_out;
    logic        mn_carry;
    logic [4:0]  hsteps;
    logic [5:0]  hr_sum;
    logic [5:0]  hr_out;
    logic        day_up;
    logic        day_dn;
    logic [16:0] mjd;
    logic [17:0] mjd_adj;
    logic [17:0] didx_full;

    assign hr_in  = {block_c[0], block_d[15:12]};
    assign mn_in  = block_d[11:6];
    assign neg    = block_d[5];
    assign halves = block_d[4:0];
    assign mjd    = {block_b[1:0], block_c[15:1]};

    // minute: thirty single steps when the half-hour count is odd
    always_comb begin
        mn_out   = mn_in;
        mn_carry = 1'b0;
        if (halves[0]) begin
            if (neg) begin
                if (mn_in >= 6'd30) begin
                    mn_out = mn_in - 6'd30;
                end else begin
                    mn_out   = mn_in + 6'd30;
                    mn_carry = 1'b1;
                end
            end else begin
                if (mn_in <= 6'd29) begin
                    mn_out = mn_in + 6'd30;
                end else if (mn_in <= 6'd59) begin
                    mn_out   = mn_in - 6'd30;
                    mn_carry = 1'b1;
                end else begin
                    mn_out   = 6'd29;
                    mn_carry = 1'b1;
                end
            end
        end
    end

    assign hsteps = {1'b0, halves[4:1]} + {4'd0, mn_carry};
    assign hr_sum = {1'b0, hr_in} + {1'b0, hsteps};

    // hour: at most sixteen steps, so at most one wrap
    always_comb begin
        hr_out = {1'b0, hr_in};
        day_up = 1'b0;
        day_dn = 1'b0;
        if (neg) begin
            if (hsteps <= hr_in) begin
                hr_out = {1'b0, hr_in} - {1'b0, hsteps};
            end else begin
                hr_out = hr_sum + 6'd24 - {1'b0, hsteps} - {1'b0, hsteps};
                day_dn = 1'b1;
            end
        end else if (hsteps != 5'd0) begin
            if (hr_in >= 5'd23) begin
                hr_out = {1'b0, hsteps} - 6'd1;
                day_up = 1'b1;
            end else if (hr_sum > 6'd23) begin
                hr_out = hr_sum - 6'd24;
                day_up = 1'b1;
            end else begin
                hr_out = hr_sum;
            end
        end
    end

    // day shift and window check; a negative mjd wraps high and fails the check
    assign mjd_adj   = {1'b0, mjd} + {17'd0, day_up} - {17'd0, day_dn};
    assign didx_full = mjd_adj - 18'(rdsctd_pkg::MJD_LOW);

    assign tadj.hour     = hr_out[4:0];
    assign tadj.minute   = mn_out;
    assign tadj.in_range = (mjd_adj >= 18'(rdsctd_pkg::MJD_LOW)) &&
                           (mjd_adj <= 18'(rdsctd_pkg::MJD_HIGH));
    assign tadj.day_idx  = didx_full[rdsctd_pkg::DIDX_W-1:0];

endmodule

// ===== rtl/core/rdsctd_date_walk.sv =====
// ----------------------------------------------------------------------------
// rdsctd_date_walk
// Converts a day index to year, month and day: a binary search over the
// year-start ROM, each probe a request state and then a compare state,
// then a month walk one month a cycle. Holds the last in-range date.
// ----------------------------------------------------------------------------
module rdsctd_date_walk (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  rdsctd_pkg::tadj_t          tadj,
    output rdsctd_pkg::date_t          held,
    output rdsctd_pkg::dres_t          dres
);

    typedef enum logic [2:0] {
        D_IDLE,
        D_REQ,
        D_CMP,
        D_BASE,
        D_MONTH
    } dstate_t;

    localparam int unsigned YW = rdsctd_pkg::YEAR_W;
    localparam int unsigned DW = rdsctd_pkg::DIDX_W;

    localparam logic [3:0] MON_FEB   = 4'd2;
    localparam logic [3:0] MON_APR   = 4'd4;
    localparam logic [3:0] MON_JUN   = 4'd6;
    localparam logic [3:0] MON_SEP   = 4'd9;
    localparam logic [3:0] MON_NOV   = 4'd11;
    localparam logic [3:0] MON_LIMIT = 4'd13;

    dstate_t              state_reg;
    logic [DW-1:0]        d_reg;
    logic [YW-1:0]        lo_reg;
    logic [YW-1:0]        hi_reg;
    logic [YW-1:0]        mid_reg;
    logic [3:0]           m_reg;
    rdsctd_pkg::date_t    held_reg;
    logic                 done_reg;
    logic                 valid_reg;

    logic [YW-1:0]        span;
    logic [YW-1:0]        mid;
    logic [YW-1:0]        rom_addr;
    logic [rdsctd_pkg::BASE_W-1:0] rom_data;
    logic [4:0]           mlen;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // search probe address, or the final year base once the window closes
    assign span     = hi_reg - lo_reg;
    assign mid      = lo_reg + (span >> 1);
    assign rom_addr = (state_reg == D_REQ && span > YW'(1)) ? mid : lo_reg;
    assign mlen     = month_len(m_reg, lo_reg[1:0] == 2'b00);

    rdsctd_year_rom u_year_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // sequencer and held date
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            held_reg  <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                D_IDLE: begin
                    done_reg <= start && !tadj.in_range;
                    if (start) begin
                        if (tadj.in_range) begin
                            d_reg     <= tadj.day_idx;
                            lo_reg    <= '0;
                            hi_reg    <= YW'(rdsctd_pkg::YEAR_COUNT);
                            state_reg <= D_REQ;
                        end else begin
                            valid_reg <= 1'b0;
                        end
                    end
                end
                D_REQ: begin
                    done_reg <= 1'b0;
                    if (span > YW'(1)) begin
                        mid_reg   <= mid;
                        state_reg <= D_CMP;
                    end else begin
                        state_reg <= D_BASE;
                    end
                end
                D_CMP: begin
                    done_reg <= 1'b0;
                    if (d_reg > rom_data) begin
                        lo_reg <= mid_reg;
                    end else begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= D_REQ;
                end
                D_BASE: begin
                    done_reg  <= 1'b0;
                    d_reg     <= d_reg - rom_data;
                    m_reg     <= 4'd1;
                    state_reg <= D_MONTH;
                end
                D_MONTH: begin
                    if (m_reg == MON_LIMIT || d_reg <= DW'(mlen)) begin
                        held_reg.year  <= lo_reg;
                        held_reg.month <= m_reg;
                        held_reg.day   <= d_reg[4:0];
                        done_reg       <= 1'b1;
                        valid_reg      <= 1'b1;
                        state_reg      <= D_IDLE;
                    end else begin
                        done_reg <= 1'b0;
                        d_reg    <= d_reg - DW'(mlen);
                        m_reg    <= m_reg + 4'd1;
                    end
                end
                default: begin
                    done_reg  <= 1'b0;
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign held          = held_reg;
    assign dres.done     = done_reg;
    assign dres.in_range = valid_reg;

    // completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("date walk done held high");

    // a new conversion starts only from idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == D_IDLE)
        else $error("date walk started while busy");

    // search window never exceeds the table
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == D_REQ || state_reg == D_CMP) |->
            (lo_reg < hi_reg && hi_reg <= YW'(rdsctd_pkg::YEAR_COUNT)))
        else $error("year search window out of range");

    // an in-range result always carries a real month
    a_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && valid_reg) |-> (held_reg.month >= 4'd1 && held_reg.month <= 4'd12))
        else $error("held month out of range");

endmodule

// ===== rtl/core/rds_clock_time_date_decoder_top.sv =====
// sequence: an out-of-range date is flagged straight from the walk's idle state; otherwise
// up to 7 year-ROM probes (request state, then compare state), a final base read and
// up to 12 month steps come before the result beat is offered
// throughput: one group per conversion; the next beat is taken once the result is
// registered, while that result may still wait on m_tready
// reset: synchronous active-low aresetn clears the held date to year 2000, month 0, day 0
// ----------------------------------------------------------------------------
// rds_clock_time_date_decoder_top
// RDS group 4A clock-time decoder: local time from blocks C and D, calendar
// date from the MJD through a year-start ROM and a month walk.
// ----------------------------------------------------------------------------
module rds_clock_time_date_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // block_b[15:0], block_c[31:16], block_d[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // year[11:0], month[15:12], day[20:16], hour[25:21],
                                   // minute[31:26], date_in_range[32], zero[39:33]
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_HOLD
    } tstate_t;

    tstate_t             state_reg;
    logic                start_reg;
    rdsctd_pkg::tadj_t   tadj_reg;
    logic                m_tvalid_reg;
    logic [11:0]         year_reg;
    logic [3:0]          month_reg;
    logic [4:0]          day_reg;
    logic [4:0]          hour_reg;
    logic [5:0]          minute_reg;
    logic                in_range_reg;

    rdsctd_pkg::tadj_t   tadj;
    rdsctd_pkg::date_t   held;
    rdsctd_pkg::dres_t   dres;
    logic                s_beat;
    logic                out_free;
    logic                load_out;

    rdsctd_time_adj u_time_adj (
        .block_b (s_tdata[15:0]),
        .block_c (s_tdata[31:16]),
        .block_d (s_tdata[47:32]),
        .tadj    (tadj)
    );

    rdsctd_date_walk u_date_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .tadj    (tadj_reg),
        .held    (held),
        .dres    (dres)
    );

    assign s_tready = (state_reg == T_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = ((state_reg == T_RUN && dres.done) || state_reg == T_HOLD) && out_free;

    // control and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            start_reg <= s_beat;
            if (load_out) begin
                year_reg     <= 12'd2000 + 12'(held.year);
                month_reg    <= held.month;
                day_reg      <= held.day;
                hour_reg     <= tadj_reg.hour;
                minute_reg   <= tadj_reg.minute;
                in_range_reg <= dres.in_range;
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (s_beat) begin
                        tadj_reg  <= tadj;
                        state_reg <= T_RUN;
                    end
                end
                T_RUN: begin
                    if (dres.done) begin
                        state_reg <= out_free ? T_IDLE : T_HOLD;
                    end
                end
                T_HOLD: begin
                    if (out_free) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, in_range_reg, minute_reg, hour_reg, day_reg, month_reg, year_reg};

    // one group in flight: after a beat the input side closes
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("input taken while a group is in flight");

    // date results only come back while a group is being converted
    a_done_run: assert property (@(posedge aclk) disable iff (!aresetn)
        dres.done |-> state_reg == T_RUN)
        else $error("date result without a group in flight");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !load_out)
        else $error("result register overwritten");

endmodule
